@@ design/jog_shuttle_report_decoder_unit_assert.svh @@
// Assertion macros for the jog/shuttle report decoder.
// Included by the top level; no other dependencies.
`ifndef JOG_SHUTTLE_REPORT_DECODER_UNIT_ASSERT_SVH
`define JOG_SHUTTLE_REPORT_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JSRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jsrd same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define JSRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jsrd next-cycle check failed");

`endif

@@ design/jsrd_pkg.sv @@
// Shared types and constants of the jog/shuttle report decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsrd_pkg;

  localparam int unsigned BtnWidth   = 16;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  localparam logic [6:0] PadLen  = 7'd5;
  localparam logic [6:0] KnobLen = 7'd64;

  localparam logic [7:0] CodeA   = 8'h06;
  localparam logic [7:0] CodeB   = 8'h03;
  localparam logic [7:0] CodeC   = 8'h7d;
  localparam logic [7:0] CodeJog = 8'h07;
  localparam logic [7:0] DirUp   = 8'h01;
  localparam logic [7:0] DirDown = 8'h02;

  localparam logic [3:0] KnobIdxA = 4'd6;
  localparam logic [3:0] KnobIdxB = 4'd7;
  localparam logic [3:0] KnobIdxC = 4'd5;

  localparam logic [4:0] RevBase = 5'd16;

  localparam logic DevPad  = 1'b0;
  localparam logic DevKnob = 1'b1;

  localparam logic ActReport = 1'b0;

  typedef enum logic [2:0] {
    EvJogUp    = 3'd0,
    EvJogDown  = 3'd1,
    EvPress    = 3'd2,
    EvRelease  = 3'd3,
    EvShutFwd  = 3'd4,
    EvShutRev  = 3'd5
  } event_kind_e;

  typedef struct packed {
    event_kind_e kind;
    logic [3:0]  idx;
    logic [4:0]  speed;
  } event_t;

  // One decoded item: a leading event, a run of button edges, a trailing jog.
  typedef struct packed {
    logic                pre_v;
    event_t              pre;
    logic [BtnWidth-1:0] mask;
    logic [BtnWidth-1:0] newb;
    logic                post_v;
    logic                post_down;
  } job_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

`default_nettype wire

@@ design/jsrd_front.sv @@
// Front end: accepts items, tracks device state and builds event jobs.
// Depends on jsrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsrd_front #(
  parameter int unsigned BUTTON_COUNT = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                action_i,
  input  wire logic [6:0]          report_length_i,
  input  wire logic [7:0]          shuttle_byte_i,
  input  wire logic [7:0]          jog_byte_i,
  input  wire logic [7:0]          byte_three_i,
  input  wire logic [7:0]          byte_four_i,
  input  wire logic [7:0]          byte_five_i,
  input  jsrd_pkg::q_status_t      q_status_i,
  output logic                     push_o,
  output jsrd_pkg::job_t           job_o,
  output logic                     device_kind_o
);

  localparam logic [jsrd_pkg::BtnWidth-1:0] BtnMask =
    jsrd_pkg::BtnWidth'((33'd1 << BUTTON_COUNT) - 33'd1);

  logic                            device_kind_q;
  logic [jsrd_pkg::BtnWidth-1:0]   buttons_q, buttons_d;
  logic [7:0]                      jog_q, jog_d;
  logic [7:0]                      shuttle_q, shuttle_d;
  logic [7:0]                      code_q, code_d;
  logic                            accept;
  logic [jsrd_pkg::BtnWidth-1:0]   newb;
  logic                            a_now, a_was, b_now, b_was, c_now, c_was;
  jsrd_pkg::job_t                  job;

  assign in_ready_o    = !q_status_i.full;
  assign accept        = in_valid_i && in_ready_o;
  assign newb          = {byte_four_i, byte_three_i};
  assign device_kind_o = device_kind_q;

  assign a_now = byte_five_i == jsrd_pkg::CodeA;
  assign a_was = code_q == jsrd_pkg::CodeA;
  assign b_now = byte_five_i == jsrd_pkg::CodeB;
  assign b_was = code_q == jsrd_pkg::CodeB;
  assign c_now = byte_five_i == jsrd_pkg::CodeC;
  assign c_was = code_q == jsrd_pkg::CodeC;

  always_comb begin
    job       = '0;
    buttons_d = buttons_q;
    jog_d     = jog_q;
    shuttle_d = shuttle_q;
    code_d    = code_q;
    if (action_i != jsrd_pkg::ActReport) begin
      if (shuttle_q[7:3] == 5'd0 && shuttle_q[2:0] != 3'd0) begin
        job.pre_v       = 1'b1;
        job.pre.kind    = jsrd_pkg::EvShutFwd;
        job.pre.speed   = {2'b00, shuttle_q[2:0]};
      end else if (shuttle_q[7:4] == 4'hf) begin
        job.pre_v       = 1'b1;
        job.pre.kind    = jsrd_pkg::EvShutRev;
        job.pre.speed   = jsrd_pkg::RevBase - {1'b0, shuttle_q[3:0]};
      end
    end else if (device_kind_q == jsrd_pkg::DevPad && report_length_i == jsrd_pkg::PadLen) begin
      if (jog_byte_i == 8'(jog_q + 8'd1)) begin
        job.pre_v    = 1'b1;
        job.pre.kind = jsrd_pkg::EvJogUp;
      end else if (jog_byte_i != jog_q) begin
        job.pre_v    = 1'b1;
        job.pre.kind = jsrd_pkg::EvJogDown;
      end
      job.mask  = (newb ^ buttons_q) & BtnMask;
      job.newb  = newb;
      buttons_d = newb;
      jog_d     = jog_byte_i;
      shuttle_d = shuttle_byte_i;
    end else if (device_kind_q == jsrd_pkg::DevKnob && report_length_i == jsrd_pkg::KnobLen) begin
      priority if (a_now != a_was) begin
        job.pre_v    = 1'b1;
        job.pre.kind = a_now ? jsrd_pkg::EvPress : jsrd_pkg::EvRelease;
        job.pre.idx  = jsrd_pkg::KnobIdxA;
      end else if (b_now != b_was) begin
        job.pre_v    = 1'b1;
        job.pre.kind = b_now ? jsrd_pkg::EvPress : jsrd_pkg::EvRelease;
        job.pre.idx  = jsrd_pkg::KnobIdxB;
      end else if (c_now != c_was) begin
        job.pre_v    = 1'b1;
        job.pre.kind = c_now ? jsrd_pkg::EvPress : jsrd_pkg::EvRelease;
        job.pre.idx  = jsrd_pkg::KnobIdxC;
      end else begin
        job.pre_v    = 1'b0;
      end
      if (byte_five_i == jsrd_pkg::CodeJog) begin
        job.post_v    = byte_three_i == jsrd_pkg::DirUp || byte_three_i == jsrd_pkg::DirDown;
        job.post_down = byte_three_i == jsrd_pkg::DirDown;
      end
      code_d = byte_five_i;
    end
  end

  assign job_o  = job;
  assign push_o = accept && (job.pre_v || (|job.mask) || job.post_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_kind_q <= jsrd_pkg::DevPad;
      buttons_q     <= '0;
      jog_q         <= '0;
      shuttle_q     <= '0;
      code_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        device_kind_q <= cfg_wdata_i;
      end
      if (accept) begin
        buttons_q <= buttons_d;
        jog_q     <= jog_d;
        shuttle_q <= shuttle_d;
        code_q    <= code_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/jsrd_queue.sv @@
// Short job queue between front and back end.
// Depends on jsrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsrd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  jsrd_pkg::job_t       push_job_i,
  input  wire logic            pop_i,
  output jsrd_pkg::job_t       head_o,
  output jsrd_pkg::q_status_t  status_o
);

  jsrd_pkg::job_t                   slots_q [jsrd_pkg::QueueDepth];
  logic [jsrd_pkg::QueuePtrW-1:0]   wr_q, rd_q;
  logic [jsrd_pkg::QueuePtrW:0]     count_q;

  assign head_o            = slots_q[rd_q];
  assign status_o.full     = count_q == (jsrd_pkg::QueuePtrW + 1)'(jsrd_pkg::QueueDepth);
  assign status_o.nonempty = count_q != '0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/jsrd_back.sv @@
// Back end: walks one job at a time and emits its events into the output register.
// Depends on jsrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsrd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  jsrd_pkg::job_t        head_i,
  input  jsrd_pkg::q_status_t   q_status_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [2:0]            event_kind_o,
  output logic [3:0]            button_index_o,
  output logic [4:0]            shuttle_speed_o,
  output logic                  last_event_o
);

  logic                 busy_q;
  jsrd_pkg::job_t       job_q;
  logic                 out_valid_q;
  jsrd_pkg::event_t     ev_q, ev_d;
  logic                 last_q, last_d;
  jsrd_pkg::job_t       cur, rem;
  logic                 have, advance;
  logic [3:0]           low_idx;

  assign cur     = busy_q ? job_q : head_i;
  assign have    = busy_q || q_status_i.nonempty;
  assign advance = have && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && !busy_q;

  always_comb begin
    low_idx = '0;
    for (int i = jsrd_pkg::BtnWidth - 1; i >= 0; i--) begin
      if (cur.mask[i]) begin
        low_idx = 4'(i);
      end
    end
  end

  always_comb begin
    rem  = cur;
    ev_d = '0;
    if (cur.pre_v) begin
      ev_d      = cur.pre;
      rem.pre_v = 1'b0;
    end else if (|cur.mask) begin
      ev_d.kind = cur.newb[low_idx] ? jsrd_pkg::EvPress : jsrd_pkg::EvRelease;
      ev_d.idx  = low_idx;
      rem.mask  = cur.mask & (cur.mask - 1'b1);
    end else begin
      ev_d.kind  = cur.post_down ? jsrd_pkg::EvJogDown : jsrd_pkg::EvJogUp;
      rem.post_v = 1'b0;
    end
    last_d = !rem.pre_v && (rem.mask == '0) && !rem.post_v;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ev_q   <= ev_d;
      last_q <= last_d;
      job_q  <= rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        busy_q      <= !last_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = ev_q.kind;
  assign button_index_o  = ev_q.idx;
  assign shuttle_speed_o = ev_q.speed;
  assign last_event_o    = last_q;

endmodule

`default_nettype wire

@@ design/jog_shuttle_report_decoder_unit.sv @@
// Jog/shuttle report decoder top level: front end, job queue and back end.
// Depends on jsrd_pkg, jsrd_front, jsrd_queue, jsrd_back and the assert header.
// An item is decoded into a job as it is accepted; the job waits in a four-deep
// queue, and the back end emits one event per cycle from it while the output is
// not stalled. A pad report with a jog change and all sixteen buttons toggled
// yields 17 events, a knob report up to 2, a tick 1, and an item that yields
// nothing is not queued. The input side keeps accepting while the queue has
// room, independent of the output stall; the first event of an item passes
// through the queue and then the back end's output register before it shows.
`timescale 1ns / 1ps
`default_nettype none

`include "jog_shuttle_report_decoder_unit_assert.svh"

module jog_shuttle_report_decoder_unit #(
  parameter int unsigned BUTTON_COUNT = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [6:0]  report_length_i,
  input  wire logic [7:0]  shuttle_byte_i,
  input  wire logic [7:0]  jog_byte_i,
  input  wire logic [7:0]  byte_three_i,
  input  wire logic [7:0]  byte_four_i,
  input  wire logic [7:0]  byte_five_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       event_kind_o,
  output logic [3:0]       button_index_o,
  output logic [4:0]       shuttle_speed_o,
  output logic             last_event_o
);

  jsrd_pkg::q_status_t q_status;
  jsrd_pkg::job_t      push_job, head_job;
  logic                push, pop;
  logic                device_kind;
  logic                ev_shuttle, ev_button;

  jsrd_front #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .report_length_i,
    .shuttle_byte_i,
    .jog_byte_i,
    .byte_three_i,
    .byte_four_i,
    .byte_five_i,
    .q_status_i    (q_status),
    .push_o        (push),
    .job_o         (push_job),
    .device_kind_o (device_kind)
  );

  jsrd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .status_o   (q_status)
  );

  jsrd_back u_back (
    .clk_i,
    .rst_ni,
    .head_i     (head_job),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_valid_o,
    .out_ready_i,
    .event_kind_o,
    .button_index_o,
    .shuttle_speed_o,
    .last_event_o
  );

  assign ev_shuttle = out_valid_o && (event_kind_o == jsrd_pkg::EvShutFwd ||
                                      event_kind_o == jsrd_pkg::EvShutRev);
  assign ev_button  = out_valid_o && (event_kind_o == jsrd_pkg::EvPress ||
                                      event_kind_o == jsrd_pkg::EvRelease);

  `JSRD_ASSERT_NOW(a_no_push_when_full, clk_i, rst_ni, push, !q_status.full)
  `JSRD_ASSERT_NOW(a_no_pop_when_empty, clk_i, rst_ni, pop, q_status.nonempty)
  `JSRD_ASSERT_NOW(a_shuttle_fields, clk_i, rst_ni, ev_shuttle, button_index_o == 4'd0 && shuttle_speed_o != 5'd0)
  `JSRD_ASSERT_NOW(a_button_speed_zero, clk_i, rst_ni, ev_button, shuttle_speed_o == 5'd0)
  `JSRD_ASSERT_NEXT(a_kind_stable_cfg, clk_i, rst_ni, cfg_we_i, device_kind == $past(cfg_wdata_i))

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking bench for jog_shuttle_report_decoder_unit: pad and knob reports and
// shuttle ticks go in, a local decoder predicts each event, and the events coming
// out are compared. Depends on jsrd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ButtonCount = 16;
  localparam int unsigned QuietLimit  = 3000;
  localparam logic        ActTick     = 1'b1;
  localparam logic [7:0]  FwdMax      = 8'h07;
  localparam logic [7:0]  RevLow      = 8'hf0;

  typedef struct packed {
    logic       action;
    logic [6:0] len;
    logic [7:0] shuttle;
    logic [7:0] jog;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] code;
  } report_t;

  typedef struct packed {
    jsrd_pkg::event_kind_e kind;
    logic [3:0]            idx;
    logic [4:0]            speed;
    logic                  last;
  } decoded_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic [2:0] event_kind_o;
  logic [3:0] button_index_o;
  logic [4:0] shuttle_speed_o;
  logic last_event_o;

  report_t on_wire = '0;
  logic    action_i;
  logic [6:0] report_length_i;
  logic [7:0] shuttle_byte_i, jog_byte_i, byte_three_i, byte_four_i, byte_five_i;

  assign action_i        = on_wire.action;
  assign report_length_i = on_wire.len;
  assign shuttle_byte_i  = on_wire.shuttle;
  assign jog_byte_i      = on_wire.jog;
  assign byte_three_i    = on_wire.lo;
  assign byte_four_i     = on_wire.hi;
  assign byte_five_i     = on_wire.code;

  jog_shuttle_report_decoder_unit #(
    .BUTTON_COUNT(ButtonCount)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .report_length_i (report_length_i),
    .shuttle_byte_i  (shuttle_byte_i),
    .jog_byte_i      (jog_byte_i),
    .byte_three_i    (byte_three_i),
    .byte_four_i     (byte_four_i),
    .byte_five_i     (byte_five_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_kind_o    (event_kind_o),
    .button_index_o  (button_index_o),
    .shuttle_speed_o (shuttle_speed_o),
    .last_event_o    (last_event_o)
  );

  report_t        report_backlog[$];
  decoded_event_t due_events[$];
  decoded_event_t fresh_events[$];
  decoded_event_t want;

  // decoder shadow state
  logic        knob_mode = jsrd_pkg::DevPad;
  logic [15:0] held_buttons = '0;
  logic [7:0]  jog_count = '0;
  logic [7:0]  shuttle_pos = '0;
  logic [7:0]  last_code = '0;

  // generator shadows
  logic [15:0] gen_buttons = '0;
  logic [7:0]  gen_jog = '0;
  logic [7:0]  gen_dir = '0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned ready_run = 0;
  int unsigned ready_pick;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic report_t mk(input logic action, input logic [6:0] len,
                                 input logic [7:0] shuttle, input logic [7:0] jog,
                                 input logic [7:0] lo, input logic [7:0] hi,
                                 input logic [7:0] code);
    report_t r;
    r = '{action, len, shuttle, jog, lo, hi, code};
    return r;
  endfunction

  function automatic void add_event(input jsrd_pkg::event_kind_e kind,
                                    input logic [3:0] idx, input logic [4:0] speed);
    decoded_event_t ev;
    ev = '{kind, idx, speed, 1'b0};
    fresh_events.push_back(ev);
  endfunction

  task automatic decode_report(input report_t r);
    logic [15:0] nb;
    fresh_events.delete();
    if (r.action == ActTick) begin
      if (shuttle_pos >= 8'd1 && shuttle_pos <= FwdMax) begin
        add_event(jsrd_pkg::EvShutFwd, 4'd0, shuttle_pos[4:0]);
      end else if (shuttle_pos >= RevLow) begin
        add_event(jsrd_pkg::EvShutRev, 4'd0, jsrd_pkg::RevBase - {1'b0, shuttle_pos[3:0]});
      end
    end else if (knob_mode == jsrd_pkg::DevPad && r.len == jsrd_pkg::PadLen) begin
      nb = {r.hi, r.lo};
      if (r.jog == jog_count + 8'd1) begin
        add_event(jsrd_pkg::EvJogUp, 4'd0, 5'd0);
      end else if (r.jog != jog_count) begin
        add_event(jsrd_pkg::EvJogDown, 4'd0, 5'd0);
      end
      for (int i = 0; i < ButtonCount; i++) begin
        if (nb[i] && !held_buttons[i]) begin
          add_event(jsrd_pkg::EvPress, 4'(i), 5'd0);
        end else if (!nb[i] && held_buttons[i]) begin
          add_event(jsrd_pkg::EvRelease, 4'(i), 5'd0);
        end
      end
      held_buttons = nb;
      jog_count = r.jog;
      shuttle_pos = r.shuttle;
    end else if (knob_mode == jsrd_pkg::DevKnob && r.len == jsrd_pkg::KnobLen) begin
      if ((r.code == jsrd_pkg::CodeA) != (last_code == jsrd_pkg::CodeA)) begin
        add_event((r.code == jsrd_pkg::CodeA) ? jsrd_pkg::EvPress : jsrd_pkg::EvRelease,
                  jsrd_pkg::KnobIdxA, 5'd0);
      end else if ((r.code == jsrd_pkg::CodeB) != (last_code == jsrd_pkg::CodeB)) begin
        add_event((r.code == jsrd_pkg::CodeB) ? jsrd_pkg::EvPress : jsrd_pkg::EvRelease,
                  jsrd_pkg::KnobIdxB, 5'd0);
      end else if ((r.code == jsrd_pkg::CodeC) != (last_code == jsrd_pkg::CodeC)) begin
        add_event((r.code == jsrd_pkg::CodeC) ? jsrd_pkg::EvPress : jsrd_pkg::EvRelease,
                  jsrd_pkg::KnobIdxC, 5'd0);
      end
      if (r.code == jsrd_pkg::CodeJog) begin
        if (r.lo == jsrd_pkg::DirUp) begin
          add_event(jsrd_pkg::EvJogUp, 4'd0, 5'd0);
        end else if (r.lo == jsrd_pkg::DirDown) begin
          add_event(jsrd_pkg::EvJogDown, 4'd0, 5'd0);
        end
      end
      last_code = r.code;
    end
    if (fresh_events.size() != 0) begin
      fresh_events[fresh_events.size() - 1].last = 1'b1;
    end
    foreach (fresh_events[k]) begin
      due_events.push_back(fresh_events[k]);
    end
  endtask

  task automatic set_mode(input logic mode);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    knob_mode = mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (report_backlog.size() != 0 || in_valid_i || due_events.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (8) @(negedge clk_i);
  endtask

  task automatic queue_random(input int unsigned count);
    report_t r;
    for (int n = 0; n < count; n++) begin
      r.action = ($urandom_range(0, 99) < 15) ? ActTick : jsrd_pkg::ActReport;
      r.len = ($urandom_range(0, 99) < 85)
              ? ((knob_mode == jsrd_pkg::DevPad) ? jsrd_pkg::PadLen : jsrd_pkg::KnobLen)
              : 7'($urandom_range(0, 64));
      case ($urandom_range(0, 5))
        0, 1: r.shuttle = 8'($urandom_range(1, 7));
        2, 3: r.shuttle = 8'($urandom_range(8'hf0, 8'hff));
        default: r.shuttle = 8'($urandom_range(0, 255));
      endcase
      r.hi = 8'($urandom_range(0, 255));
      if (knob_mode == jsrd_pkg::DevPad) begin
        case ($urandom_range(0, 3))
          0: r.jog = gen_jog + 8'd1;
          1: r.jog = gen_jog;
          2: r.jog = gen_jog - 8'd1;
          default: r.jog = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 3))
          0: {r.hi, r.lo} = gen_buttons ^ (16'h1 << $urandom_range(0, 15));
          1: {r.hi, r.lo} = gen_buttons ^ (16'($urandom) & 16'($urandom) & 16'($urandom));
          2: {r.hi, r.lo} = 16'($urandom);
          default: {r.hi, r.lo} = ~gen_buttons;
        endcase
        r.code = 8'($urandom_range(0, 255));
        if (r.action == jsrd_pkg::ActReport && r.len == jsrd_pkg::PadLen) begin
          gen_jog = r.jog;
          gen_buttons = {r.hi, r.lo};
        end
      end else begin
        r.jog = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
          0: r.code = jsrd_pkg::CodeA;
          1: r.code = jsrd_pkg::CodeB;
          2: r.code = jsrd_pkg::CodeC;
          3, 4: r.code = jsrd_pkg::CodeJog;
          default: r.code = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 3))
          0: r.lo = jsrd_pkg::DirUp;
          1: r.lo = jsrd_pkg::DirDown;
          2: r.lo = gen_dir;
          default: r.lo = 8'($urandom_range(0, 255));
        endcase
        gen_dir = r.lo;
      end
      report_backlog.push_back(r);
    end
  endtask

  // driver: bursts of items separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      on_wire <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        decode_report(on_wire);
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (report_backlog.size() != 0) begin
        on_wire <= report_backlog.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= $urandom_range(0, 1) ? $urandom_range(1, 20) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: check each event, stall in runs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_run <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_events.size() == 0) begin
          $display("%0t: unexpected event: kind %0d idx %0d speed %0d last %0d", $time,
                   event_kind_o, button_index_o, shuttle_speed_o, last_event_o);
          fail_count++;
        end else begin
          want = due_events.pop_front();
          if (event_kind_o !== want.kind) begin
            $display("%0t: event_kind expected %0d actual %0d", $time, want.kind,
                     event_kind_o);
            fail_count++;
          end
          if (button_index_o !== want.idx) begin
            $display("%0t: button_index expected %0d actual %0d", $time, want.idx,
                     button_index_o);
            fail_count++;
          end
          if (shuttle_speed_o !== want.speed) begin
            $display("%0t: shuttle_speed expected %0d actual %0d", $time, want.speed,
                     shuttle_speed_o);
            fail_count++;
          end
          if (last_event_o !== want.last) begin
            $display("%0t: last_event expected %0d actual %0d", $time, want.last,
                     last_event_o);
            fail_count++;
          end
        end
      end
      if (ready_run == 0) begin
        ready_pick = $urandom_range(0, 7);
        if (ready_pick < 4) begin
          out_ready_i <= 1'b1;
          ready_run <= $urandom_range(1, 40);
        end else if (ready_pick < 7) begin
          out_ready_i <= 1'b0;
          ready_run <= $urandom_range(1, 12);
        end else begin
          out_ready_i <= ~out_ready_i;
          ready_run <= $urandom_range(0, 2);
        end
      end else begin
        ready_run <= ready_run - 1;
      end
    end
  end

  // watchdog: no item moved while work is outstanding
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (report_backlog.size() == 0 && !in_valid_i && due_events.size() == 0)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_mode(jsrd_pkg::DevPad);
    report_backlog.push_back(mk(ActTick, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::PadLen, 8'h07, 8'h01,
                                8'hff, 8'hff, 8'h00));
    report_backlog.push_back(mk(ActTick, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::PadLen, 8'hf0, 8'h01,
                                8'h00, 8'h00, 8'h00));
    report_backlog.push_back(mk(ActTick, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::PadLen, 8'hff, 8'h00,
                                8'h5a, 8'ha5, 8'h00));
    report_backlog.push_back(mk(ActTick, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::PadLen, 8'h01, 8'hff,
                                8'h5a, 8'ha5, 8'h00));
    report_backlog.push_back(mk(ActTick, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::PadLen, 8'h08, 8'h00,
                                8'h5a, 8'ha5, 8'h00));
    report_backlog.push_back(mk(ActTick, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, 7'd4, 8'h03, 8'h55,
                                8'hff, 8'hff, 8'h00));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::KnobLen, 8'h03, 8'h55,
                                8'hff, 8'hff, 8'h06));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::PadLen, 8'hef, 8'h00,
                                8'h5a, 8'ha5, 8'h00));
    report_backlog.push_back(mk(ActTick, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    queue_random(70);
    drain();

    set_mode(jsrd_pkg::DevKnob);
    // walk the code edges both ways around the jog directions
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::KnobLen, 8'h00, 8'h00,
                                8'h00, 8'h00, jsrd_pkg::CodeA));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::KnobLen, 8'h00, 8'h00,
                                8'h00, 8'h00, jsrd_pkg::CodeA));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::KnobLen, 8'h00, 8'h00,
                                8'h00, 8'h00, jsrd_pkg::CodeB));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::KnobLen, 8'h00, 8'h00,
                                8'h00, 8'h00, jsrd_pkg::CodeC));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::KnobLen, 8'h00, 8'h00,
                                jsrd_pkg::DirUp, 8'h00, jsrd_pkg::CodeJog));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::KnobLen, 8'h00, 8'h00,
                                jsrd_pkg::DirDown, 8'h00, jsrd_pkg::CodeJog));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::KnobLen, 8'h00, 8'h00,
                                8'h05, 8'h00, jsrd_pkg::CodeJog));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::KnobLen, 8'h00, 8'h00,
                                8'h00, 8'h00, jsrd_pkg::CodeC));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::KnobLen, 8'h00, 8'h00,
                                8'h00, 8'h00, jsrd_pkg::CodeB));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::KnobLen, 8'h00, 8'h00,
                                8'h00, 8'h00, jsrd_pkg::CodeA));
    report_backlog.push_back(mk(jsrd_pkg::ActReport, jsrd_pkg::PadLen, 8'h03, 8'h01,
                                8'h00, 8'h00, jsrd_pkg::CodeB));
    report_backlog.push_back(mk(ActTick, 7'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    queue_random(70);
    drain();

    set_mode(jsrd_pkg::DevPad);
    queue_random(75);
    drain();
    set_mode(jsrd_pkg::DevKnob);
    queue_random(75);
    drain();
    set_mode(jsrd_pkg::DevPad);
    queue_random(70);
    drain();
    set_mode(jsrd_pkg::DevKnob);
    queue_random(40);
    drain();

    repeat (12) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/jsrd_pkg.sv
design/jsrd_front.sv
design/jsrd_queue.sv
design/jsrd_back.sv
design/jog_shuttle_report_decoder_unit.sv
verif/testbench.sv
